@@ rtl/core/led_matrix_scan_dimmer_unit_macros.svh @@
// ----------------------------------------------------------------------------
// LED matrix scan dimmer assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_SCAN_DIMMER_UNIT_MACROS_SVH
`define LED_MATRIX_SCAN_DIMMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// check on every edge outside reset
`define LMSD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check on every edge, reset included
`define LMSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LMSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define LMSD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/core/lmsd_pkg.sv @@
// ----------------------------------------------------------------------------
// LED matrix scan dimmer package
// Field widths, command codes, request and response types.
// ----------------------------------------------------------------------------
package lmsd_pkg;

  // default geometry
  localparam int NUM_ROWS_DEF   = 4;
  localparam int NUM_COLS_DEF   = 8;
  localparam int NUM_PHASES_DEF = 32;

  // field widths
  localparam int CMD_W   = 3;
  localparam int IDX_W   = 5;
  localparam int LVL_W   = 8;
  localparam int ANODE_W = 4;
  localparam int CATH_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_SET   = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_TEST  = 3'd3,
    CMD_LEVEL = 3'd4
  } lmsd_cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] led_index;
    logic [LVL_W-1:0] level;
  } lmsd_req_t;

  typedef struct packed {
    logic [ANODE_W-1:0] anode_enable;
    logic [CATH_W-1:0]  cathode_pattern;
    logic               led_is_on;
  } lmsd_rsp_t;

  // decoded operation of one accepted request, already qualified
  typedef struct packed {
    logic tick;
    logic set_on;
    logic clr_on;
    logic test_on;
    logic wr_lvl;
  } lmsd_op_t;

  // drive state after the request
  typedef struct packed {
    logic [ANODE_W-1:0] anode_enable;
    logic [CATH_W-1:0]  cathode_pattern;
  } lmsd_drive_t;

endpackage

@@ rtl/core/lmsd_out_skid.sv @@
// ----------------------------------------------------------------------------
// LED matrix scan dimmer output stage
// Result register plus one skid entry, so input takes requests while a
// result waits on a stalled output.
// ----------------------------------------------------------------------------
`include "led_matrix_scan_dimmer_unit_macros.svh"

module lmsd_out_skid
  import lmsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  lmsd_rsp_t rsp_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output lmsd_rsp_t out_rsp_o
);

  logic      out_vld_q;
  logic      skid_vld_q;
  lmsd_rsp_t out_q;
  lmsd_rsp_t skid_q;
  logic      out_free;

  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= push_i;
      end
    end else if (push_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  // payload: drain skid first to keep order
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= rsp_i;
      end
    end else if (push_i) begin
      skid_q <= rsp_i;
    end
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  `LMSD_ASSERT_ALWAYS(a_skid_behind_out, clk_i, skid_vld_q |-> out_vld_q, "skid holds data while output register is empty")
  `LMSD_ASSERT(a_stall_fills_skid, clk_i, rst_ni, (out_vld_q && out_stall_i && push_i) |=> skid_vld_q, "request lost while output stalled")
  `LMSD_ASSERT(a_skid_from_stall, clk_i, rst_ni, $rose(skid_vld_q) |-> $past(out_stall_i), "skid filled without an output stall")

endmodule

@@ rtl/core/lmsd_led_store.sv @@
// ----------------------------------------------------------------------------
// LED matrix scan dimmer LED store
// Per-row on-bits and per-LED levels, one write and one read row each.
// ----------------------------------------------------------------------------
module lmsd_led_store
  import lmsd_pkg::*;
#(
  parameter int NUM_ROWS = NUM_ROWS_DEF,
  parameter int NUM_COLS = NUM_COLS_DEF,
  localparam int RW  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1,
  localparam int CLW = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lmsd_op_t                       op_i,
  input  logic [RW-1:0]                  idx_row_i,
  input  logic [CLW-1:0]                 idx_col_i,
  input  logic [LVL_W-1:0]               level_i,
  input  logic [RW-1:0]                  row_next_i,
  input  logic [RW-1:0]                  scan_row_i,
  output logic [NUM_COLS-1:0]            rd_on_o,
  output logic [NUM_COLS-1:0][LVL_W-1:0] row_lvl_o,
  output logic                           led_is_on_o
);

  logic [NUM_COLS-1:0]            on_q  [NUM_ROWS];
  logic [NUM_COLS-1:0][LVL_W-1:0] lvl_q [NUM_ROWS];
  logic [RW-1:0]                  rd_row;

  // a tick reads the next scan row, everything else the addressed row
  assign rd_row = op_i.tick ? row_next_i : idx_row_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        on_q[r] <= '0;
      end
    end else if (op_i.set_on) begin
      on_q[idx_row_i][idx_col_i] <= 1'b1;
    end else if (op_i.clr_on) begin
      on_q[idx_row_i][idx_col_i] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        lvl_q[r] <= '0;
      end
    end else if (op_i.wr_lvl) begin
      lvl_q[idx_row_i][idx_col_i] <= level_i;
    end
  end

  assign rd_on_o     = on_q[rd_row];
  assign row_lvl_o   = lvl_q[scan_row_i];
  assign led_is_on_o = op_i.test_on && rd_on_o[idx_col_i];

endmodule

@@ rtl/core/lmsd_scan.sv @@
// ----------------------------------------------------------------------------
// LED matrix scan dimmer row scan
// Row and phase counters, cathode latch and per-column dimming compare.
// ----------------------------------------------------------------------------
`include "led_matrix_scan_dimmer_unit_macros.svh"

module lmsd_scan
  import lmsd_pkg::*;
#(
  parameter int NUM_ROWS   = NUM_ROWS_DEF,
  parameter int NUM_COLS   = NUM_COLS_DEF,
  parameter int NUM_PHASES = NUM_PHASES_DEF,
  localparam int RW  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1,
  localparam int PHW = $clog2(NUM_PHASES),
  localparam int AW  = (NUM_ROWS > ANODE_W) ? NUM_ROWS : ANODE_W,
  localparam int CPW = (NUM_COLS > CATH_W) ? NUM_COLS : CATH_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lmsd_op_t                       op_i,
  input  logic [NUM_COLS-1:0]            row_on_i,
  input  logic [NUM_COLS-1:0][LVL_W-1:0] row_lvl_i,
  output logic [RW-1:0]                  row_o,
  output logic [RW-1:0]                  row_next_o,
  output lmsd_drive_t                    drive_o
);

  logic [RW-1:0]       row_q, row_d;
  logic [PHW-1:0]      phase_q, phase_d;
  logic [NUM_COLS-1:0] latch_q, latch_d;
  logic                live_q, live_d;
  logic [AW-1:0]       anode_oh;
  logic [CPW-1:0]      cath_pad;

  assign row_next_o = (row_q == RW'(NUM_ROWS - 1)) ? '0 : row_q + 1'b1;

  always_comb begin
    row_d   = row_q;
    phase_d = phase_q;
    latch_d = latch_q;
    live_d  = live_q;
    if (op_i.tick) begin
      phase_d = (phase_q == PHW'(NUM_PHASES - 1)) ? '0 : phase_q + 1'b1;
      if (phase_q == '0) begin
        row_d   = row_next_o;
        latch_d = row_on_i;
        live_d  = 1'b1;
      end else begin
        // drop columns whose level the phase has passed
        for (int c = 0; c < NUM_COLS; c++) begin
          if (LVL_W'(phase_q) > row_lvl_i[c]) begin
            latch_d[c] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      phase_q <= '0;
      latch_q <= '0;
      live_q  <= 1'b0;
    end else begin
      row_q   <= row_d;
      phase_q <= phase_d;
      latch_q <= latch_d;
      live_q  <= live_d;
    end
  end

  assign anode_oh = live_d ? (AW'(1) << row_d) : '0;
  assign cath_pad = CPW'(latch_d);

  assign row_o                   = row_q;
  assign drive_o.anode_enable    = anode_oh[ANODE_W-1:0];
  assign drive_o.cathode_pattern = cath_pad[CATH_W-1:0];

  `LMSD_ASSERT(a_phase_range, clk_i, rst_ni, phase_q <= PHW'(NUM_PHASES - 1), "phase counter out of range")
  `LMSD_ASSERT(a_row_range, clk_i, rst_ni, row_q <= RW'(NUM_ROWS - 1), "row counter out of range")
  `LMSD_ASSERT(a_dim_only_clears, clk_i, rst_ni, (op_i.tick && (phase_q != '0)) |-> ((latch_d & ~latch_q) == '0), "dimming phase turned a cathode on")
  `LMSD_ASSERT(a_dark_before_scan, clk_i, rst_ni, !live_q |-> (latch_q == '0), "cathodes driven before the first row")

endmodule

@@ rtl/core/led_matrix_scan_dimmer_unit.sv @@
// ----------------------------------------------------------------------------
// LED matrix scan dimmer
// Multiplexed LED matrix row scan with per-LED dimming over a phase cycle.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  request | in        | in_valid_i / in_stall_o  | in_req_i  (lmsd_req_t)
//  result  | out       | out_valid_o / out_stall_i| out_rsp_o (lmsd_rsp_t)
//
//  One request per cycle while in_stall_o is low; its result is registered.
//  The work is one decode, one row read of the LED store and eight level
//  compares between the request edge and the result register.
//  Reset clears control state and the LED store at once; no clearing pass.
//  The output has a result register and one skid entry: input stalls only
//  when both hold results that the output has not taken.
// ----------------------------------------------------------------------------
module led_matrix_scan_dimmer_unit
  import lmsd_pkg::*;
#(
  parameter int NUM_ROWS   = NUM_ROWS_DEF,
  parameter int NUM_COLS   = NUM_COLS_DEF,
  parameter int NUM_PHASES = NUM_PHASES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  lmsd_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output lmsd_rsp_t out_rsp_o
);

  localparam int RW  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int CLW = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;

  logic                           acc;
  logic                           full;
  logic                           idx_ok;
  logic [RW-1:0]                  idx_row;
  logic [CLW-1:0]                 idx_col;
  lmsd_op_t                       op;
  logic [RW-1:0]                  scan_row;
  logic [RW-1:0]                  row_next;
  logic [NUM_COLS-1:0]            rd_on;
  logic [NUM_COLS-1:0][LVL_W-1:0] row_lvl;
  logic                           led_is_on;
  lmsd_drive_t                    drive;
  lmsd_rsp_t                      rsp;

  assign in_stall_o = full;
  assign acc        = in_valid_i && !full;

  // split index into row and column by range compare per row
  always_comb begin
    idx_row = '0;
    idx_col = '0;
    idx_ok  = int'(in_req_i.led_index) < NUM_ROWS * NUM_COLS;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if ((int'(in_req_i.led_index) >= r * NUM_COLS) &&
          (int'(in_req_i.led_index) < (r + 1) * NUM_COLS)) begin
        idx_row = RW'(r);
        idx_col = CLW'(int'(in_req_i.led_index) - r * NUM_COLS);
      end
    end
  end

  always_comb begin
    op         = '0;
    if (acc) begin
      case (in_req_i.cmd)
        CMD_TICK:  op.tick    = 1'b1;
        CMD_SET:   op.set_on  = idx_ok;
        CMD_CLEAR: op.clr_on  = idx_ok;
        CMD_TEST:  op.test_on = idx_ok;
        CMD_LEVEL: op.wr_lvl  = idx_ok;
        default:   op         = '0;
      endcase
    end
  end

  lmsd_led_store #(
    .NUM_ROWS (NUM_ROWS),
    .NUM_COLS (NUM_COLS)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .idx_row_i   (idx_row),
    .idx_col_i   (idx_col),
    .level_i     (in_req_i.level),
    .row_next_i  (row_next),
    .scan_row_i  (scan_row),
    .rd_on_o     (rd_on),
    .row_lvl_o   (row_lvl),
    .led_is_on_o (led_is_on)
  );

  lmsd_scan #(
    .NUM_ROWS   (NUM_ROWS),
    .NUM_COLS   (NUM_COLS),
    .NUM_PHASES (NUM_PHASES)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .row_on_i   (rd_on),
    .row_lvl_i  (row_lvl),
    .row_o      (scan_row),
    .row_next_o (row_next),
    .drive_o    (drive)
  );

  assign rsp.anode_enable    = drive.anode_enable;
  assign rsp.cathode_pattern = drive.cathode_pattern;
  assign rsp.led_is_on       = led_is_on;

  lmsd_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (acc),
    .rsp_i       (rsp),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
